// ===== hdl/crx_pkg.sv =====
package crx_pkg;

  // Field widths of one received beat and one result beat
  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 4;
  localparam int unsigned PosW   = 5;
  localparam int unsigned TxCntW = 9;

  // Default largest payload; a shorter declared length ends the message
  localparam int unsigned MAX_PAYLOAD_DEF = 15;

  // Header byte layout
  localparam int unsigned HDR_TYPE_BIT = 7;

  // Command codes
  localparam logic CMD_RX_BYTE  = 1'b0;
  localparam logic CMD_TX_START = 1'b1;

  // Decoder positions inside a chunk
  localparam logic [PosW-1:0] POS_IDLE = PosW'(0);
  localparam logic [PosW-1:0] POS_SEQ  = PosW'(1);
  localparam logic [PosW-1:0] POS_BODY = PosW'(2);

  typedef struct packed {
    logic             cmd;
    logic [ByteW-1:0] rx_byte;
    logic             chunk_first;
    logic             chunk_last;
  } crx_item_t;

  typedef struct packed {
    logic              data_valid;
    logic [ByteW-1:0]  data_byte;
    logic              message_end;
    logic              message_abort;
    logic              ack_valid;
    logic [ByteW-1:0]  ack_seq;
    logic              ack_complete;
    logic [TxCntW-1:0] tx_expected;
    logic              tx_finished;
  } crx_res_t;

endpackage

// ===== hdl/crx_if.sv =====
interface crx_in_if import crx_pkg::*;;
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [ByteW-1:0] rx_byte;
  logic             chunk_first;
  logic             chunk_last;

  modport source (output valid, cmd, rx_byte, chunk_first, chunk_last, input ready);
  modport sink   (input valid, cmd, rx_byte, chunk_first, chunk_last, output ready);
endinterface

interface crx_out_if import crx_pkg::*;;
  logic              valid;
  logic              ready;
  logic              data_valid;
  logic [ByteW-1:0]  data_byte;
  logic              message_end;
  logic              message_abort;
  logic              ack_valid;
  logic [ByteW-1:0]  ack_seq;
  logic              ack_complete;
  logic [TxCntW-1:0] tx_expected;
  logic              tx_finished;

  modport source (output valid, data_valid, data_byte, message_end, message_abort,
                  ack_valid, ack_seq, ack_complete, tx_expected, tx_finished,
                  input ready);
  modport sink   (input valid, data_valid, data_byte, message_end, message_abort,
                  ack_valid, ack_seq, ack_complete, tx_expected, tx_finished,
                  output ready);
endinterface

// ===== hdl/crx_core.sv =====
module crx_core import crx_pkg::*; #(
  parameter int unsigned MaxPayload = MAX_PAYLOAD_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  crx_item_t item_i,
  output crx_res_t  res_o
);

  logic [PosW-1:0]   pos_q, pos_d;
  logic              is_data_q, is_data_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [ByteW-1:0]  seq_q, seq_d;
  logic              done_arm_q, done_arm_d;
  logic              in_msg_q, in_msg_d;
  logic [TxCntW-1:0] tx_exp_q, tx_exp_d;
  logic              tx_done_q, tx_done_d;

  logic              finish;
  logic              short_chunk;
  logic [PosW-1:0]   last_pos;

  assign short_chunk = len_q < LenW'(MaxPayload);
  assign last_pos    = {{(PosW-LenW){1'b0}}, len_q} + PosW'(1);

  // Decode one beat against the chunk state
  always_comb begin
    pos_d      = pos_q;
    is_data_d  = is_data_q;
    len_d      = len_q;
    seq_d      = seq_q;
    done_arm_d = done_arm_q;
    in_msg_d   = in_msg_q;
    tx_exp_d   = tx_exp_q;
    tx_done_d  = tx_done_q;
    finish     = 1'b0;
    res_o      = '0;

    if (item_i.cmd == CMD_TX_START) begin
      tx_exp_d  = '0;
      tx_done_d = 1'b0;
    end else if (item_i.chunk_first) begin
      done_arm_d = 1'b0;
      if (item_i.chunk_last) begin
        // drop malformed header-only chunk
        pos_d = POS_IDLE;
      end else begin
        is_data_d = item_i.rx_byte[HDR_TYPE_BIT];
        len_d     = item_i.rx_byte[LenW-1:0];
        pos_d     = POS_SEQ;
      end
    end else if (pos_q == POS_SEQ) begin
      seq_d = item_i.rx_byte;
      if (is_data_q) begin
        if (item_i.rx_byte == '0 && in_msg_q) begin
          res_o.message_abort = 1'b1;
          in_msg_d            = 1'b0;
        end
        if (len_q == '0 || item_i.chunk_last) finish = 1'b1;
        else pos_d = POS_BODY;
      end else begin
        if ({1'b0, item_i.rx_byte} == tx_exp_q && !tx_exp_q[TxCntW-1]) begin
          tx_exp_d   = tx_exp_q + TxCntW'(1);
          done_arm_d = 1'b1;
        end
        if (item_i.chunk_last) begin
          pos_d      = POS_IDLE;
          done_arm_d = 1'b0;
        end else begin
          pos_d = POS_BODY;
        end
      end
    end else if (pos_q >= POS_BODY) begin
      if (is_data_q) begin
        res_o.data_valid = 1'b1;
        res_o.data_byte  = item_i.rx_byte;
        if (pos_q == last_pos || item_i.chunk_last) finish = 1'b1;
        else pos_d = pos_q + PosW'(1);
      end else begin
        if (done_arm_q && item_i.rx_byte != '0) tx_done_d = 1'b1;
        done_arm_d = 1'b0;
        pos_d      = POS_IDLE;
      end
    end

    // Close a data chunk and emit its ack
    if (finish) begin
      res_o.message_end  = short_chunk;
      in_msg_d           = !short_chunk;
      res_o.ack_valid    = 1'b1;
      res_o.ack_seq      = seq_d;
      res_o.ack_complete = short_chunk;
      pos_d              = POS_IDLE;
    end

    res_o.tx_expected = tx_exp_d;
    res_o.tx_finished = tx_done_d;
  end

  // Advance state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= POS_IDLE;
      is_data_q  <= 1'b0;
      len_q      <= '0;
      seq_q      <= '0;
      done_arm_q <= 1'b0;
      in_msg_q   <= 1'b0;
      tx_exp_q   <= '0;
      tx_done_q  <= 1'b0;
    end else if (step_i) begin
      pos_q      <= pos_d;
      is_data_q  <= is_data_d;
      len_q      <= len_d;
      seq_q      <= seq_d;
      done_arm_q <= done_arm_d;
      in_msg_q   <= in_msg_d;
      tx_exp_q   <= tx_exp_d;
      tx_done_q  <= tx_done_d;
    end
  end

endmodule

// ===== hdl/chunk_reassembly_with_ack.sv =====
// Chunk reassembly with acknowledgement.
// rx_i carries one link byte per beat with its chunk_first / chunk_last
// marks, or a start command (cmd) that clears transmit tracking.
// res_o returns exactly one result beat per input beat: a forwarded
// payload byte, message end/abort flags, an ack to send back, and the
// transmit counter and done flag after that beat.
// The result beat is registered and valid in the cycle after the beat is
// accepted. Throughput: one beat per cycle while the receiver keeps up, set
// by the single decode stage between the chunk state and result registers.
// rx_i.ready stays high while the result register is empty or being
// drained, so a new beat is taken in the same cycle a result leaves.
// If the receiver stalls, the result register holds its beat and
// rx_i.ready drops until res_o.ready returns.
// Reset clears the chunk decoder, the message state, the transmit
// counter and done flag, and empties the result register.
module chunk_reassembly_with_ack import crx_pkg::*; #(
  parameter int unsigned MaxPayload = MAX_PAYLOAD_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  crx_in_if.sink     rx_i,
  crx_out_if.source  res_o
);

  crx_item_t item;
  crx_res_t  res;
  crx_res_t  res_q;
  logic      out_valid_q;
  logic      step;

  assign item.cmd         = rx_i.cmd;
  assign item.rx_byte     = rx_i.rx_byte;
  assign item.chunk_first = rx_i.chunk_first;
  assign item.chunk_last  = rx_i.chunk_last;

  // Take a beat whenever the result register is free or draining
  assign rx_i.ready = !out_valid_q || res_o.ready;
  assign step       = rx_i.valid && rx_i.ready;

  crx_core #(
    .MaxPayload (MaxPayload)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item),
    .res_o  (res)
  );

  // Hold the result beat until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      out_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.data_valid    = res_q.data_valid;
  assign res_o.data_byte     = res_q.data_byte;
  assign res_o.message_end   = res_q.message_end;
  assign res_o.message_abort = res_q.message_abort;
  assign res_o.ack_valid     = res_q.ack_valid;
  assign res_o.ack_seq       = res_q.ack_seq;
  assign res_o.ack_complete  = res_q.ack_complete;
  assign res_o.tx_expected   = res_q.tx_expected;
  assign res_o.tx_finished   = res_q.tx_finished;

endmodule
